[rtl/urpr_pkg.sv]
// Shared types and constants for the UART receiver with parity and edge resync.
`timescale 1ns / 1ps

package urpr_pkg;

    localparam int BIT_PERIOD_W = 16;
    localparam int DATA_BITS_W  = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int BITS_TAKEN_W = 4;
    localparam int BYTE_W       = 8;
    localparam int EVENT_W      = 2;

    localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RST    = 16'd5208;
    localparam logic [DATA_BITS_W-1:0]  DATA_BITS_RST     = 4'd8;
    localparam logic                    PARITY_ENABLE_RST = 1'b0;
    localparam logic [DATA_BITS_W-1:0]  MIN_DATA_BITS     = 4'd5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_BITS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PARITY_ENABLE = 2'd2;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_NONE       = 2'd0;
    localparam logic [EVENT_W-1:0] EV_BYTE       = 2'd1;
    localparam logic [EVENT_W-1:0] EV_PARITY_ERR = 2'd2;
    localparam logic [EVENT_W-1:0] EV_FRAME_ERR  = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DATA   = 3'd1,
        PH_PARITY = 3'd2,
        PH_STOP   = 3'd3,
        PH_HALT   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [BIT_PERIOD_W-1:0] bit_period;
        logic [DATA_BITS_W-1:0]  data_bits;
        logic                    parity_enable;
    } cfg_t;

    typedef struct packed {
        logic line_level;
        logic resume;
    } in_req_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_code;
        logic [BYTE_W-1:0]  rx_byte;
    } out_req_t;

endpackage

[rtl/urpr_rx_core.sv]
// Frame state machine: bit timing, data shift, parity and stop checks.
`timescale 1ns / 1ps

module urpr_rx_core #(
    parameter int MAX_DATA_BITS = 8,
    parameter int COUNT_WIDTH   = 17
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  urpr_pkg::in_req_t  req,
    input  urpr_pkg::cfg_t     cfg,
    output urpr_pkg::out_req_t result
);

    localparam int LOAD_W = (COUNT_WIDTH > urpr_pkg::BIT_PERIOD_W + 1) ?
                            COUNT_WIDTH : urpr_pkg::BIT_PERIOD_W + 1;
    localparam logic [LOAD_W-1:0] CNT_MAX = LOAD_W'({COUNT_WIDTH{1'b1}});
    localparam logic [urpr_pkg::DATA_BITS_W-1:0] MAX_BITS =
        urpr_pkg::DATA_BITS_W'(MAX_DATA_BITS);

    urpr_pkg::phase_t                     phase_reg, phase_next;
    logic                                 last_level_reg, last_level_next;
    logic [COUNT_WIDTH-1:0]               cnt_reg, cnt_next;
    logic [MAX_DATA_BITS-1:0]             shift_reg, shift_next;
    logic [urpr_pkg::BITS_TAKEN_W-1:0]    bits_reg, bits_next;

    logic [COUNT_WIDTH-1:0]               cnt_dec;
    logic [LOAD_W-1:0]                    resync_sum;
    logic [LOAD_W-1:0]                    period_ext;
    logic [COUNT_WIDTH-1:0]               resync_load;
    logic [COUNT_WIDTH-1:0]               period_load;
    logic [urpr_pkg::DATA_BITS_W-1:0]     eff_bits;
    logic                                 line_edge;
    logic                                 take;
    logic [MAX_DATA_BITS-1:0]             shift_set;
    logic [urpr_pkg::BITS_TAKEN_W-1:0]    bits_inc;
    logic                                 parity_acc;

    // Timing, data-width, shift and parity helpers
    always_comb begin
        cnt_dec     = (cnt_reg != '0) ? cnt_reg - 1'b1 : '0;
        resync_sum  = LOAD_W'(cfg.bit_period) + LOAD_W'(cfg.bit_period >> 1);
        period_ext  = LOAD_W'(cfg.bit_period);
        resync_load = (resync_sum > CNT_MAX) ? {COUNT_WIDTH{1'b1}}
                                             : resync_sum[COUNT_WIDTH-1:0];
        period_load = (period_ext > CNT_MAX) ? {COUNT_WIDTH{1'b1}}
                                             : period_ext[COUNT_WIDTH-1:0];
        line_edge   = req.line_level != last_level_reg;
        take        = line_edge || (cnt_dec == '0);

        if (cfg.data_bits < urpr_pkg::MIN_DATA_BITS) begin
            eff_bits = urpr_pkg::MIN_DATA_BITS;
        end else if (cfg.data_bits > MAX_BITS) begin
            eff_bits = MAX_BITS;
        end else begin
            eff_bits = cfg.data_bits;
        end

        shift_set = shift_reg;
        for (int i = 0; i < MAX_DATA_BITS; i++) begin
            if (req.line_level && (bits_reg == urpr_pkg::BITS_TAKEN_W'(i))) begin
                shift_set[i] = 1'b1;
            end
        end
        bits_inc = bits_reg + 1'b1;

        parity_acc = 1'b0;
        for (int i = 0; i < MAX_DATA_BITS; i++) begin
            if (urpr_pkg::DATA_BITS_W'(i) < eff_bits) begin
                parity_acc = parity_acc ^ shift_reg[i];
            end
        end
    end

    // Next state and result
    always_comb begin
        phase_next        = phase_reg;
        last_level_next   = req.line_level;
        cnt_next          = cnt_dec;
        shift_next        = shift_reg;
        bits_next         = bits_reg;
        result.event_code = urpr_pkg::EV_NONE;
        result.rx_byte    = '0;

        case (phase_reg)
            urpr_pkg::PH_IDLE: begin
                if (!req.line_level) begin
                    cnt_next   = resync_load;
                    phase_next = urpr_pkg::PH_DATA;
                    shift_next = '0;
                    bits_next  = '0;
                end
            end
            urpr_pkg::PH_DATA: begin
                if (take) begin
                    cnt_next   = line_edge ? resync_load : period_load;
                    shift_next = shift_set;
                    bits_next  = bits_inc;
                    if (bits_inc >= eff_bits) begin
                        if (cfg.parity_enable) begin
                            phase_next = urpr_pkg::PH_PARITY;
                        end else begin
                            result.event_code = urpr_pkg::EV_BYTE;
                            result.rx_byte    = urpr_pkg::BYTE_W'(shift_set);
                            phase_next        = urpr_pkg::PH_STOP;
                        end
                    end
                end
            end
            urpr_pkg::PH_PARITY: begin
                if (take) begin
                    cnt_next = line_edge ? resync_load : period_load;
                    if (parity_acc ^ req.line_level) begin
                        result.event_code = urpr_pkg::EV_BYTE;
                        result.rx_byte    = urpr_pkg::BYTE_W'(shift_reg);
                    end else begin
                        result.event_code = urpr_pkg::EV_PARITY_ERR;
                    end
                    phase_next = urpr_pkg::PH_STOP;
                end
            end
            urpr_pkg::PH_STOP: begin
                if (take) begin
                    if (req.line_level) begin
                        phase_next = urpr_pkg::PH_IDLE;
                    end else begin
                        result.event_code = urpr_pkg::EV_FRAME_ERR;
                        phase_next        = urpr_pkg::PH_HALT;
                    end
                end
            end
            default: begin
                phase_next = req.resume ? urpr_pkg::PH_IDLE : urpr_pkg::PH_HALT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= urpr_pkg::PH_IDLE;
            last_level_reg <= 1'b1;
            cnt_reg        <= '0;
            shift_reg      <= '0;
            bits_reg       <= '0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            last_level_reg <= last_level_next;
            cnt_reg        <= cnt_next;
            shift_reg      <= shift_next;
            bits_reg       <= bits_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_frame_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (result.event_code == urpr_pkg::EV_FRAME_ERR)
        |=> phase_reg == urpr_pkg::PH_HALT)
        else $error("framing error did not halt the receiver");

    a_bits_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_reg <= MAX_BITS)
        else $error("bit count ran past the data width");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (phase_reg == urpr_pkg::PH_IDLE)
        |-> result.event_code == urpr_pkg::EV_NONE)
        else $error("event reported while awaiting a start bit");
`endif

endmodule

[rtl/uart_receiver_parity_resync_top.sv]
// Top level of the UART receiver with parity check and edge resync.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_req     in         s_valid / s_ready  line_level, resume (one line sample)
// m_req     out        m_valid / m_ready  event_code, rx_byte (one per sample)
// cfg       in         cfg_wr_en          cfg_index, cfg_wr_data (no wait)
//
// Each accepted sample yields one result request; one sample per cycle while s_ready.
// A sample is decoded in the cycle it is accepted; its result is registered.
// The result side has a two-entry buffer (output plus skid), so s_ready is a
// register and one more sample can be accepted into skid after m_ready drops.
// Reset (aresetn low, synchronous) returns to awaiting a start bit, line idle high.

module uart_receiver_parity_resync_top #(
    parameter int MAX_DATA_BITS = 8,
    parameter int COUNT_WIDTH   = 17
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  urpr_pkg::in_req_t                   s_req,
    output logic                                m_valid,
    input  logic                                m_ready,
    output urpr_pkg::out_req_t                  m_req,
    input  logic                                cfg_wr_en,
    input  logic [urpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [urpr_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    urpr_pkg::cfg_t     cfg_reg;
    urpr_pkg::out_req_t core_result;
    urpr_pkg::out_req_t main_reg, main_next;
    urpr_pkg::out_req_t skid_reg, skid_next;
    logic               main_valid_reg, main_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    logic               s_fire;

    // Configuration registers: take a write whenever the enable is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_period    <= urpr_pkg::BIT_PERIOD_RST;
            cfg_reg.data_bits     <= urpr_pkg::DATA_BITS_RST;
            cfg_reg.parity_enable <= urpr_pkg::PARITY_ENABLE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                urpr_pkg::REG_BIT_PERIOD: begin
                    cfg_reg.bit_period <= cfg_wr_data[urpr_pkg::BIT_PERIOD_W-1:0];
                end
                urpr_pkg::REG_DATA_BITS: begin
                    cfg_reg.data_bits <= cfg_wr_data[urpr_pkg::DATA_BITS_W-1:0];
                end
                urpr_pkg::REG_PARITY_ENABLE: begin
                    cfg_reg.parity_enable <= cfg_wr_data[0];
                end
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Accept a sample whenever the skid entry is free
    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;

    urpr_rx_core #(
        .MAX_DATA_BITS (MAX_DATA_BITS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (s_fire),
        .req     (s_req),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // Output buffer: refill the output entry from skid first, else from the core;
    // park a new result in skid while the output entry is stalled.
    always_comb begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = core_result;
                main_valid_next = s_fire;
            end
        end else if (s_fire) begin
            skid_next       = core_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload holds need no reset
    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_valid = main_valid_reg;
    assign m_req   = main_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry holds a result with the output entry empty");

    a_stall_parks: assert property (@(posedge aclk) disable iff (!aresetn)
        main_valid_reg && !m_ready && s_fire |=> skid_valid_reg)
        else $error("result lost while the output was stalled");
`endif

endmodule
